/* hw/rtl/wzsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wzsc_pkg
// Shared constants, register indexes and sequencer states of the window
// z-score spike cleaner.
// ----------------------------------------------------------------------------
package wzsc_pkg;

  localparam int MAX_WINDOW_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int WHW_BITS      = 4;
  localparam int Z_BITS        = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_HALF_WIDTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_Z_THRESHOLD       = 2'd1;

  localparam logic [WHW_BITS-1:0] WHW_RESET = 4'd5;
  localparam logic [Z_BITS-1:0]   Z_RESET   = 16'd768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLAN,
    ST_SCAN,
    ST_CHK,
    ST_CQ,
    ST_S2,
    ST_CX,
    ST_DEV2,
    ST_LHS,
    ST_ZZ,
    ST_ZZC,
    ST_RHS,
    ST_DIV,
    ST_SGN,
    ST_OUT,
    ST_SHIFT
  } state_t;

endpackage

/* hw/rtl/wzsc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wzsc channel interfaces
// Valid/ready channels for samples, cleaned results and register writes.
// ----------------------------------------------------------------------------
interface wzsc_in_if #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface wzsc_out_if #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] cleaned_value;
  logic                   spike_flag;
  logic                   run_last;
  logic                   signal_end;

  modport source (output valid, cleaned_value, spike_flag, run_last, signal_end,
                  input ready);
  modport sink   (input valid, cleaned_value, spike_flag, run_last, signal_end,
                  output ready);
endinterface

interface wzsc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [wzsc_pkg::CFG_IDX_BITS-1:0]  index;
  logic [wzsc_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/window_zscore_spike_cleaner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_zscore_spike_cleaner
// Sliding-window z-score outlier filter with an iterative shared datapath.
// ----------------------------------------------------------------------------
// Each sample is judged against up to W neighbors on each side (center left
// out, window clipped at the signal ends) and replaced by the rounded neighbor
// mean when its deviation exceeds z standard deviations. Results lag the input
// by W samples; a request with last_sample set flushes every pending sample.
// The block takes one request at a time and is busy until all of its results
// are taken. Per result the sequencer scans the window, then runs up to
// eight products through one shift-add multiplier that retires one
// multiplier bit per cycle and, for a spike, a restoring divider. The
// multiplier is the critical loop.
module window_zscore_spike_cleaner #(
  parameter int MAX_WINDOW  = wzsc_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = wzsc_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  wzsc_in_if.sink    in_ch,
  wzsc_out_if.source out_ch,
  wzsc_cfg_if.sink   cfg_ch
);
  import wzsc_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int DEPTH = 2 * MAX_WINDOW + 1;
  localparam int PSW   = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(2 * MAX_WINDOW + 1);
  localparam int SW    = SB + CW;
  localparam int QW    = 2 * SB + CW;
  localparam int DVW   = SB + CW + 1;
  localparam int PW    = 2 * SB + 3 * CW + 2 * Z_BITS + 2;
  localparam int NW    = SW + 1;
  localparam int RW    = CW + 2;
  localparam int NCW   = $clog2(NW + 1);

  state_t state_r, state_nxt;

  logic signed [SB-1:0] win_r [DEPTH];
  logic [PSW-1:0]       rcv_r, emit_r, w_r, j_r, end_r;
  logic                 last_r;
  logic signed [SB-1:0] x_r, y_r;
  logic signed [SW-1:0] s_r;
  logic [QW-1:0]        q_r;
  logic [CW-1:0]        c_r;
  logic [PW-1:0]        mul_a_r, mul_b_r, mul_p_r, cq_r, d_r, lhs_r;
  logic [NW-1:0]        div_n_r;
  logic [RW-1:0]        div_rem_r;
  logic [NCW-1:0]       div_cnt_r;
  logic                 flag_r;
  logic [WHW_BITS-1:0]  whw_r;
  logic [Z_BITS-1:0]    zth_r;

  logic                 in_acc, out_acc, mul_done, mul_run, mul_load;
  logic [PW-1:0]        mul_ld_a, mul_ld_b;
  logic signed [SB-1:0] v;
  logic [2*SB-1:0]      sq;
  logic [SW-1:0]        s_abs;
  logic [SB-1:0]        x_abs;
  logic signed [DVW-1:0] cx_s, dev_s;
  logic [DVW-1:0]       dev_abs;
  logic [PW-1:0]        left_w, right_w, sum_w;
  logic [PSW-1:0]       w_clamp;
  logic [RW-1:0]        rem_sh, dvs;
  logic                 run_last, sig_end;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign mul_done = (mul_b_r == '0);

  assign v     = win_r[j_r[IW-1:0]];
  assign sq    = unsigned'((2*SB)'(v) * (2*SB)'(v));
  assign s_abs = s_r[SW-1] ? unsigned'(-s_r) : unsigned'(s_r);
  assign x_abs = x_r[SB-1] ? (~unsigned'(x_r) + 1'b1) : unsigned'(x_r);
  assign cx_s  = x_r[SB-1] ? -signed'({1'b0, mul_p_r[DVW-2:0]})
                           : signed'({1'b0, mul_p_r[DVW-2:0]});
  assign dev_s   = cx_s - DVW'(s_r);
  assign dev_abs = dev_s[DVW-1] ? unsigned'(-dev_s) : unsigned'(dev_s);

  // clipped neighbor range around the center
  assign sum_w   = PW'(emit_r) + PW'(w_r) + PW'(1);
  assign left_w  = (emit_r > w_r) ? PW'(emit_r - w_r) : '0;
  assign right_w = (sum_w < PW'(rcv_r)) ? sum_w : PW'(rcv_r);

  always_comb begin
    if (whw_r == '0) begin
      w_clamp = PSW'(1);
    end else if (int'(whw_r) > MAX_WINDOW) begin
      w_clamp = PSW'(MAX_WINDOW);
    end else begin
      w_clamp = PSW'(whw_r);
    end
  end

  assign rem_sh = {div_rem_r[RW-2:0], div_n_r[NW-1]};
  assign dvs    = RW'({c_r, 1'b0});

  assign run_last = last_r ? (emit_r + PSW'(1) == rcv_r)
                           : (rcv_r - emit_r - PSW'(1) <= w_r);
  assign sig_end  = last_r && run_last;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_PLAN;
      ST_PLAN: begin
        if (last_r) begin
          state_nxt = (emit_r < rcv_r) ? ST_SCAN : ST_IDLE;
        end else if (rcv_r - emit_r > w_r) begin
          state_nxt = ST_SCAN;
        end else if (emit_r > w_r) begin
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN:  if (j_r + PSW'(1) == end_r) state_nxt = ST_CHK;
      ST_CHK:   state_nxt = (c_r < CW'(2)) ? ST_OUT : ST_CQ;
      ST_CQ:    if (mul_done) state_nxt = ST_S2;
      ST_S2:    if (mul_done) state_nxt = (cq_r > mul_p_r) ? ST_CX : ST_OUT;
      ST_CX:    if (mul_done) state_nxt = ST_DEV2;
      ST_DEV2:  if (mul_done) state_nxt = ST_LHS;
      ST_LHS:   if (mul_done) state_nxt = ST_ZZ;
      ST_ZZ:    if (mul_done) state_nxt = ST_ZZC;
      ST_ZZC:   if (mul_done) state_nxt = ST_RHS;
      ST_RHS:   if (mul_done) state_nxt = (lhs_r > mul_p_r) ? ST_DIV : ST_OUT;
      ST_DIV:   if (div_cnt_r == '0) state_nxt = ST_SGN;
      ST_SGN:   state_nxt = ST_OUT;
      ST_OUT:   if (out_acc) state_nxt = ST_PLAN;
      ST_SHIFT: state_nxt = ST_PLAN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    in_ch.ready  = (state_r == ST_IDLE);
    out_ch.valid = (state_r == ST_OUT);
    cfg_ch.ready = 1'b1;
    out_ch.cleaned_value = y_r;
    out_ch.spike_flag    = flag_r;
    out_ch.run_last      = run_last;
    out_ch.signal_end    = sig_end;

    unique case (state_r)
      ST_CQ, ST_S2, ST_CX, ST_DEV2, ST_LHS, ST_ZZ, ST_ZZC, ST_RHS: mul_run = 1'b1;
      default: mul_run = 1'b0;
    endcase

    mul_load = (state_nxt != state_r);
    mul_ld_a = '0;
    mul_ld_b = '0;
    unique case (state_nxt)
      ST_CQ:   begin mul_ld_a = PW'(q_r);     mul_ld_b = PW'(c_r);            end
      ST_S2:   begin mul_ld_a = PW'(s_abs);   mul_ld_b = PW'(s_abs);          end
      ST_CX:   begin mul_ld_a = PW'(x_abs);   mul_ld_b = PW'(c_r);            end
      ST_DEV2: begin mul_ld_a = PW'(dev_abs); mul_ld_b = PW'(dev_abs);        end
      ST_LHS:  begin mul_ld_a = mul_p_r;      mul_ld_b = PW'(c_r - CW'(1));   end
      ST_ZZ:   begin mul_ld_a = PW'(zth_r);   mul_ld_b = PW'(zth_r);          end
      ST_ZZC:  begin mul_ld_a = mul_p_r;      mul_ld_b = PW'(c_r);            end
      ST_RHS:  begin mul_ld_a = mul_p_r;      mul_ld_b = d_r;                 end
      default: mul_load = 1'b0;
    endcase
  end

  // control state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rcv_r   <= '0;
      emit_r  <= '0;
      whw_r   <= WHW_RESET;
      zth_r   <= Z_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          REG_WINDOW_HALF_WIDTH: whw_r <= cfg_ch.data[WHW_BITS-1:0];
          REG_Z_THRESHOLD:       zth_r <= cfg_ch.data[Z_BITS-1:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE:  if (in_acc && rcv_r < PSW'(DEPTH)) rcv_r <= rcv_r + PSW'(1);
        ST_PLAN: begin
          // end of signal: start over
          if (last_r && !(emit_r < rcv_r)) begin
            rcv_r  <= '0;
            emit_r <= '0;
          end
        end
        ST_OUT:   if (out_acc) emit_r <= emit_r + PSW'(1);
        ST_SHIFT: begin
          emit_r <= emit_r - PSW'(1);
          rcv_r  <= rcv_r - PSW'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (rcv_r < PSW'(DEPTH)) win_r[rcv_r[IW-1:0]] <= signed'(in_ch.sample);
          last_r <= in_ch.last_sample;
          w_r    <= w_clamp;
        end
      end
      ST_PLAN: begin
        j_r   <= PSW'(left_w);
        end_r <= PSW'(right_w);
        s_r   <= '0;
        q_r   <= '0;
        c_r   <= '0;
      end
      ST_SCAN: begin
        if (j_r == emit_r) begin
          x_r <= v;
        end else begin
          s_r <= s_r + SW'(v);
          q_r <= q_r + QW'(sq);
          c_r <= c_r + CW'(1);
        end
        j_r <= j_r + PSW'(1);
      end
      ST_CHK: begin
        y_r    <= x_r;
        flag_r <= 1'b0;
      end
      ST_CQ:  if (mul_done) cq_r <= mul_p_r;
      ST_S2:  if (mul_done) d_r <= cq_r - mul_p_r;
      ST_LHS: if (mul_done) lhs_r <= mul_p_r << 16;
      ST_RHS: begin
        // load rounded-mean division: (2|S| + c) / 2c
        div_n_r   <= NW'({s_abs, 1'b0}) + NW'(c_r);
        div_rem_r <= '0;
        div_cnt_r <= NCW'(NW);
      end
      ST_DIV: begin
        if (div_cnt_r != '0) begin
          if (rem_sh >= dvs) begin
            div_rem_r <= rem_sh - dvs;
            div_n_r   <= {div_n_r[NW-2:0], 1'b1};
          end else begin
            div_rem_r <= rem_sh;
            div_n_r   <= {div_n_r[NW-2:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r - NCW'(1);
        end
      end
      ST_SGN: begin
        y_r    <= s_r[SW-1] ? -signed'(div_n_r[SB-1:0]) : signed'(div_n_r[SB-1:0]);
        flag_r <= 1'b1;
      end
      ST_SHIFT: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
      end
      default: ;
    endcase

    // shared shift-add multiplier, one multiplier bit per cycle
    if (mul_load) begin
      mul_a_r <= mul_ld_a;
      mul_b_r <= mul_ld_b;
      mul_p_r <= '0;
    end else if (mul_run && !mul_done) begin
      if (mul_b_r[0]) mul_p_r <= mul_p_r + mul_a_r;
      mul_a_r <= mul_a_r << 1;
      mul_b_r <= mul_b_r >> 1;
    end
  end

endmodule
